/* sv/htb_pkg.sv */
// Shared types and constants of the height texture blend unit.
// No dependencies; every other file of the block imports this package.
package htb_pkg;

	localparam int LEVEL_SLOTS    = 4;
	localparam int LVL_W          = 2;
	localparam int BOUND_W        = 9;
	localparam int HEIGHT_W       = 8;
	localparam int NOISE_W        = 5;
	localparam int SUM_W          = 10;
	localparam int TEXEL_W        = 24;
	localparam int CHAN_W         = 8;
	localparam int NUM_CHANS      = 3;
	localparam int QUOT_W         = 8;
	localparam int DIV_STAGES     = 4;
	localparam int BITS_PER_STAGE = 2;
	localparam int APB_ADDR_W     = 5;
	localparam int APB_DATA_W     = 32;

	// paddr[2] picks the bound within one level's register pair.
	localparam logic BOUND_SEL_MIN = 1'b0;
	localparam logic BOUND_SEL_MAX = 1'b1;

	typedef logic [BOUND_W-1:0] bound_t;

	typedef struct packed {
		bound_t lo;
		bound_t hi;
	} level_range_t;

	typedef enum logic [1:0] {
		BLEND_NONE,
		BLEND_ONE,
		BLEND_TWO
	} blend_mode_t;

	// One classified pixel as it waits between front and back.
	typedef struct packed {
		blend_mode_t          mode;
		logic [TEXEL_W-1:0]   texel_a;
		logic [TEXEL_W-1:0]   texel_b;
		logic [HEIGHT_W-1:0]  num;
		bound_t               den;
	} blend_job_t;

endpackage

/* sv/htb_if.sv */
// Stream interfaces of the height texture blend unit: pixel input and color output.
// Depends on htb_pkg for the field widths.
interface htb_pix_in_if import htb_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic [HEIGHT_W-1:0]        height_sample;
	logic signed [NOISE_W-1:0]  noise_offset;
	logic [TEXEL_W-1:0]         texel_level0;
	logic [TEXEL_W-1:0]         texel_level1;
	logic [TEXEL_W-1:0]         texel_level2;
	logic [TEXEL_W-1:0]         texel_level3;

	modport source (output valid, height_sample, noise_offset, texel_level0, texel_level1,
		texel_level2, texel_level3, input ready);
	modport sink (input valid, height_sample, noise_offset, texel_level0, texel_level1,
		texel_level2, texel_level3, output ready);
endinterface

interface htb_pix_out_if import htb_pkg::*;;
	logic               valid;
	logic               ready;
	logic [CHAN_W-1:0]  out_red;
	logic [CHAN_W-1:0]  out_green;
	logic [CHAN_W-1:0]  out_blue;

	modport source (output valid, out_red, out_green, out_blue, input ready);
	modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

/* sv/htb_front.sv */
// Front end: accepts pixel words, clamps the height and classifies the level hits.
// Depends on htb_pkg and htb_pix_in_if; feeds htb_queue.
module htb_front import htb_pkg::*; #(
	parameter int NUM_LEVELS = 4
) (
	htb_pix_in_if.sink    pix_in,
	input  level_range_t  ranges [LEVEL_SLOTS],
	output logic          push_valid,
	input  logic          push_ready,
	output blend_job_t    push_job
);

	logic signed [SUM_W-1:0] sum;
	logic [HEIGHT_W-1:0]     h;
	logic [LEVEL_SLOTS-1:0]  hit;
	logic [TEXEL_W-1:0]      texel [LEVEL_SLOTS];
	logic [LVL_W-1:0]        idx_a;
	logic [LVL_W-1:0]        idx_b;
	logic [1:0]              found;
	logic [BOUND_W-1:0]      diff_num;

	assign pix_in.ready = push_ready;
	assign push_valid   = pix_in.valid;

	assign texel[0] = pix_in.texel_level0;
	assign texel[1] = pix_in.texel_level1;
	assign texel[2] = pix_in.texel_level2;
	assign texel[3] = pix_in.texel_level3;

	// Height plus noise, clamped to the 8-bit range.
	assign sum = $signed({{(SUM_W-HEIGHT_W){1'b0}}, pix_in.height_sample})
		+ SUM_W'(pix_in.noise_offset);

	always_comb begin
		if (sum[SUM_W-1]) begin
			h = '0;
		end else if (sum[HEIGHT_W]) begin
			h = '1;
		end else begin
			h = sum[HEIGHT_W-1:0];
		end
	end

	always_comb begin
		for (int k = 0; k < LEVEL_SLOTS; k++) begin
			hit[k] = (k < NUM_LEVELS) && ({1'b0, h} >= ranges[k].lo)
				&& ({1'b0, h} < ranges[k].hi);
		end
	end

	// The first two hits in ascending level order.
	always_comb begin
		found = 2'd0;
		idx_a = '0;
		idx_b = '0;
		for (int k = 0; k < LEVEL_SLOTS; k++) begin
			if (hit[k]) begin
				if (found == 2'd0) begin
					idx_a = LVL_W'(k);
					found = 2'd1;
				end else if (found == 2'd1) begin
					idx_b = LVL_W'(k);
					found = 2'd2;
				end
			end
		end
	end

	assign diff_num = {1'b0, h} - ranges[idx_b].lo;

	always_comb begin
		push_job.texel_a = texel[idx_a];
		push_job.texel_b = texel[idx_b];
		push_job.num     = diff_num[HEIGHT_W-1:0];
		push_job.den     = ranges[idx_a].hi - ranges[idx_b].lo;
		case (found)
			2'd0:    push_job.mode = BLEND_NONE;
			2'd1:    push_job.mode = BLEND_ONE;
			default: push_job.mode = BLEND_TWO;
		endcase
	end

endmodule

/* sv/htb_queue.sv */
// Short job queue that decouples the classifying front from the blending back.
// Depends on htb_pkg for the job type.
module htb_queue import htb_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push_valid,
	output logic        push_ready,
	input  blend_job_t  push_job,
	output logic        pop_valid,
	input  logic        pop_ready,
	output blend_job_t  pop_job
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	blend_job_t        mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

/* sv/htb_back.sv */
// Back end: pipelined weight divider, channel blend and the output register.
// Depends on htb_pkg and htb_pix_out_if; fed by htb_queue.
module htb_back import htb_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	output logic           job_ready,
	input  blend_job_t     job,
	htb_pix_out_if.source  pix_out
);

	typedef struct packed {
		blend_mode_t          mode;
		logic [TEXEL_W-1:0]   texel_a;
		logic [TEXEL_W-1:0]   texel_b;
		bound_t               rem;
		bound_t               den;
		logic [QUOT_W-1:0]    quot;
	} div_state_t;

	// Restoring division, a few quotient bits per stage. The remainder stays below den.
	function automatic div_state_t div_step(div_state_t s);
		div_state_t          o;
		logic [BOUND_W:0]    sh;
		logic [BOUND_W:0]    diff;
		o = s;
		for (int i = 0; i < BITS_PER_STAGE; i++) begin
			sh   = {o.rem, 1'b0};
			diff = sh - {1'b0, o.den};
			if (sh >= {1'b0, o.den}) begin
				o.rem  = diff[BOUND_W-1:0];
				o.quot = {o.quot[QUOT_W-2:0], 1'b1};
			end else begin
				o.rem  = sh[BOUND_W-1:0];
				o.quot = {o.quot[QUOT_W-2:0], 1'b0};
			end
		end
		return o;
	endfunction

	div_state_t         st_init;
	div_state_t         st_s1;
	div_state_t         st_s2;
	div_state_t         st_s3;
	div_state_t         st_s4;
	logic               vld_s1;
	logic               vld_s2;
	logic               vld_s3;
	logic               vld_s4;
	logic               out_valid_q;
	logic [CHAN_W-1:0]  rgb_q [NUM_CHANS];
	logic [CHAN_W-1:0]  rgb_d [NUM_CHANS];
	logic               advance;
	logic [BOUND_W-1:0] w0;

	// The whole back pipeline moves when the output register is free or being taken.
	assign advance   = !out_valid_q || pix_out.ready;
	assign job_ready = advance;

	always_comb begin
		st_init.mode    = job.mode;
		st_init.texel_a = job.texel_a;
		st_init.texel_b = job.texel_b;
		st_init.rem     = {1'b0, job.num};
		st_init.den     = job.den;
		st_init.quot    = '0;
	end

	assign w0 = BOUND_W'(256) - {1'b0, st_s4.quot};

	always_comb begin
		logic [CHAN_W-1:0] ca;
		logic [CHAN_W-1:0] cb;
		logic [16:0]       pa;
		logic [16:0]       pb;
		logic [16:0]       mix;
		for (int c = 0; c < NUM_CHANS; c++) begin
			ca  = st_s4.texel_a[c*CHAN_W +: CHAN_W];
			cb  = st_s4.texel_b[c*CHAN_W +: CHAN_W];
			pa  = {8'b0, w0} * {9'b0, ca};
			pb  = {9'b0, st_s4.quot} * {9'b0, cb};
			mix = pa + pb;
			case (st_s4.mode)
				BLEND_ONE: rgb_d[c] = ca;
				BLEND_TWO: rgb_d[c] = mix[16] ? '1 : mix[15:8];
				default:   rgb_d[c] = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			vld_s1      <= job_valid;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			vld_s4      <= vld_s3;
			out_valid_q <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			st_s1 <= div_step(st_init);
			st_s2 <= div_step(st_s1);
			st_s3 <= div_step(st_s2);
			st_s4 <= div_step(st_s3);
			rgb_q <= rgb_d;
		end
	end

	assign pix_out.valid     = out_valid_q;
	assign pix_out.out_red   = rgb_q[0];
	assign pix_out.out_green = rgb_q[1];
	assign pix_out.out_blue  = rgb_q[2];

endmodule

/* sv/height_texture_blend_unit.sv */
// Top level of the height texture blend unit: register file, front, queue and back.
// Depends on htb_pkg, htb_if, htb_front, htb_queue and htb_back.
//
// Usage. Each pixel arrives as one word on pix_in: a heightmap sample, a signed
// noise offset and one RGB texel for each of four levels. The block clamps height
// plus noise to 0..255, finds the first two enabled levels whose [min,max) range
// holds it, and returns one color word on pix_out: black with no hit, the texel
// itself with one hit, and a weighted blend of the two texels with two hits.
// The level bounds live in eight 9-bit registers on the APB port, min and max of
// each level in turn at byte addresses 0, 4, ... 28. Write them only while no
// pixel is in flight; writes complete in the access cycle, pready is tied high.
//
// Throughput is one pixel per clock while the receiver does not stall. Each
// accepted pixel passes through the queue, then through the four-stage divider
// that produces the blend weight at two quotient bits per stage, and the blend
// then lands in the output register.
// When the receiver stalls, the output word holds and the back pipeline freezes;
// the front keeps taking pixels until the QUEUE_DEPTH-entry queue is full, then
// drops pix_in.ready. Reset clears the bounds to zero (all levels disabled),
// empties the queue and the pipeline.
module height_texture_blend_unit import htb_pkg::*; #(
	parameter int NUM_LEVELS  = 4,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [APB_ADDR_W-1:0]  paddr,
	input  logic [APB_DATA_W-1:0]  pwdata,
	output logic [APB_DATA_W-1:0]  prdata,
	output logic                   pready,
	htb_pix_in_if.sink             pix_in,
	htb_pix_out_if.source          pix_out
);

	level_range_t      ranges [LEVEL_SLOTS];
	logic              cfg_write;
	logic [LVL_W-1:0]  reg_lvl;
	logic              reg_sel;
	logic              push_valid;
	logic              push_ready;
	blend_job_t        push_job;
	logic              pop_valid;
	logic              pop_ready;
	blend_job_t        pop_job;

	// Register index is paddr[4:2]: level in the upper two bits, min or max below.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign reg_lvl   = paddr[4:3];
	assign reg_sel   = paddr[2];

	// Only the levels in use get storage; the others read back as zero.
	for (genvar k = 0; k < LEVEL_SLOTS; k++) begin : g_level
		if (k < NUM_LEVELS) begin : g_used
			level_range_t range_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					range_q <= '0;
				end else if (cfg_write && reg_lvl == LVL_W'(k)) begin
					if (reg_sel == BOUND_SEL_MAX) begin
						range_q.hi <= pwdata[BOUND_W-1:0];
					end else begin
						range_q.lo <= pwdata[BOUND_W-1:0];
					end
				end
			end

			assign ranges[k] = range_q;
		end else begin : g_unused
			assign ranges[k] = '0;
		end
	end

	always_comb begin
		if (reg_sel == BOUND_SEL_MAX) begin
			prdata = {{(APB_DATA_W-BOUND_W){1'b0}}, ranges[reg_lvl].hi};
		end else begin
			prdata = {{(APB_DATA_W-BOUND_W){1'b0}}, ranges[reg_lvl].lo};
		end
	end

	htb_front #(
		.NUM_LEVELS (NUM_LEVELS)
	) u_front (
		.pix_in     (pix_in),
		.ranges     (ranges),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	htb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	htb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (pop_valid),
		.job_ready (pop_ready),
		.job       (pop_job),
		.pix_out   (pix_out)
	);

endmodule

/* sv/htb_checker.sv */
// Port-level checker of the height texture blend unit, bound to the top level.
// Depends on htb_pkg for the channel width.
module htb_checker import htb_pkg::*; #(
	parameter int MAX_INFLIGHT = 9
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [CHAN_W-1:0]  out_red,
	input  logic [CHAN_W-1:0]  out_green,
	input  logic [CHAN_W-1:0]  out_blue
);

	localparam int CNT_W = $clog2(MAX_INFLIGHT + 2);

	logic [CNT_W-1:0] inflight_q;
	logic             in_acc;
	logic             out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Pixels taken in whose color word has not yet been delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_acc && !out_acc) begin
			inflight_q <= inflight_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			inflight_q <= inflight_q - 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable({out_red, out_green, out_blue}))
		else $error("output word changed while stalled");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != '0)
		else $error("output word without a pending pixel");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CNT_W'(MAX_INFLIGHT))
		else $error("more pixels in flight than queue and pipeline hold");

endmodule

bind height_texture_blend_unit htb_checker #(
	.MAX_INFLIGHT (QUEUE_DEPTH + 5)
) u_htb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pix_in.valid),
	.in_ready  (pix_in.ready),
	.out_valid (pix_out.valid),
	.out_ready (pix_out.ready),
	.out_red   (pix_out.out_red),
	.out_green (pix_out.out_green),
	.out_blue  (pix_out.out_blue)
);
